FILE: rtl/psf_pkg.sv
// ----------------------------------------------------------------------------
// psf_pkg
// Types, widths and constants shared by the Parker spiral field pipeline.
// ----------------------------------------------------------------------------
package psf_pkg;

    localparam int POS_W     = 32;
    localparam int SPD_W     = 12;
    localparam int RSQ_W     = 64;
    localparam int RAD_W     = 32;
    localparam int RR_W      = 96;   // rsq * rad
    localparam int MSPD_W    = 44;   // |a| * speed
    localparam int T1_W      = 84;   // |a| * speed * 2^40
    localparam int K_W       = 25;
    localparam int KM_W      = 57;   // K * |b|
    localparam int T2_W      = 89;   // K * |b| * rad
    localparam int MAG_W     = 90;
    localparam int DP_W      = 44;   // 32-bit slice of rsq*rad times speed
    localparam int DEN_W     = 108;
    localparam int D2_W      = 109;
    localparam int N2_W      = 110;
    localparam int Q_W       = 32;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;
    localparam int STAT_W    = 2;

    // (km/s) per (rad/s * AU), Q16
    localparam logic [K_W-1:0]   SPIRAL_K   = 25'd28088992;
    localparam logic [SPD_W-1:0] WIND_RESET = 12'd400;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_pos_item;

    typedef struct packed {
        logic signed [31:0]      field_x;
        logic signed [31:0]      field_y;
        logic signed [31:0]      field_z;
        logic [STAT_W-1:0]       status;
    } t_field_item;

    // travels alongside the square root
    typedef struct packed {
        logic [RSQ_W-1:0]          rsq;
        logic [2:0][POS_W-1:0]     mag;
        logic [2:0]                neg;
        logic [SPD_W-1:0]          spd;
        logic                      zero;
    } t_sq_side;

    // travels alongside the dividers
    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } t_div_side;

endpackage

FILE: rtl/psf_isqrt.sv
// ----------------------------------------------------------------------------
// psf_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module psf_isqrt
    import psf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_sq_side         i_side,
    output logic             o_vld,
    output logic [RAD_W-1:0] o_rad,
    output t_sq_side         o_side
);

    logic [SQ_STEPS-1:0] r_vld;
    logic [SQ_STEPS-1:0] n_vld;
    logic [RSQ_W-1:0]    r_n    [SQ_STEPS];
    logic [RSQ_W-1:0]    n_n    [SQ_STEPS];
    logic [RAD_W+1:0]    r_rem  [SQ_STEPS];
    logic [RAD_W+1:0]    n_rem  [SQ_STEPS];
    logic [RAD_W-1:0]    r_root [SQ_STEPS];
    logic [RAD_W-1:0]    n_root [SQ_STEPS];
    t_sq_side            r_side [SQ_STEPS];
    t_sq_side            n_side [SQ_STEPS];

    always_comb begin
        logic [RSQ_W-1:0] p_n;
        logic [RAD_W+1:0] p_rem;
        logic [RAD_W-1:0] p_root;
        logic [RAD_W+3:0] sh;
        logic [RAD_W+1:0] trial;
        logic             ge;
        for (int k = 0; k < SQ_STEPS; k++) begin
            if (k == 0) begin
                n_vld[k]  = i_vld;
                n_side[k] = i_side;
                p_n       = i_side.rsq;
                p_rem     = '0;
                p_root    = '0;
            end else begin
                n_vld[k]  = r_vld[k-1];
                n_side[k] = r_side[k-1];
                p_n       = r_n[k-1];
                p_rem     = r_rem[k-1];
                p_root    = r_root[k-1];
            end
            sh        = {p_rem, p_n[RSQ_W-1 -: 2]};
            trial     = {p_root, 2'b01};
            ge        = (sh >= {2'b00, trial});
            n_rem[k]  = ge ? (RAD_W+2)'(sh - {2'b00, trial}) : sh[RAD_W+1:0];
            n_root[k] = {p_root[RAD_W-2:0], ge};
            n_n[k]    = {p_n[RSQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < SQ_STEPS; k++) begin
                r_n[k]    <= n_n[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS-1];
    assign o_rad  = r_root[SQ_STEPS-1];
    assign o_side = r_side[SQ_STEPS-1];

endmodule

FILE: rtl/psf_prod.sv
// ----------------------------------------------------------------------------
// psf_prod
// Builds the common denominator and the three rounded-division numerators.
// ----------------------------------------------------------------------------
module psf_prod
    import psf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RAD_W-1:0] i_rad,
    input  t_sq_side         i_side,
    output logic             o_vld,
    output logic [N2_W-1:0]  o_n2 [3],
    output logic [D2_W-1:0]  o_d2,
    output t_div_side        o_side
);

    logic [4:0] r_vld;

    // stage 1
    logic [63:0]        r1_rr_lo, r1_rr_hi;
    logic [MSPD_W-1:0]  r1_mspd [3];
    logic [KM_W-1:0]    r1_km   [3];
    logic [2:0]         r1_na, r1_nb;
    logic [RAD_W-1:0]   r1_rad;
    logic [SPD_W-1:0]   r1_spd;
    logic               r1_zero;
    // stage 2
    logic [RR_W-1:0]    r2_rr;
    logic [T1_W-1:0]    r2_t1  [3];
    logic [63:0]        r2_krl [3];
    logic [KM_W-1:0]    r2_krh [3];
    logic [2:0]         r2_na, r2_nb;
    logic [SPD_W-1:0]   r2_spd;
    logic               r2_zero;
    // stage 3
    logic [DP_W-1:0]    r3_dp0, r3_dp1, r3_dp2;
    logic [T1_W-1:0]    r3_t1 [3];
    logic [T2_W-1:0]    r3_t2 [3];
    logic [2:0]         r3_na, r3_nb;
    logic               r3_zero;
    // stage 4
    logic [DEN_W-1:0]   r4_den;
    logic [MAG_W-1:0]   r4_mag [3];
    logic [2:0]         r4_neg;
    logic               r4_zero;
    // stage 5
    logic [N2_W-1:0]    r5_n2 [3];
    logic [D2_W-1:0]    r5_d2;
    logic [2:0]         r5_neg;
    logic               r5_zero;

    // component c uses (a, b) = (x, -y), (y, x), (z, 0)
    logic [POS_W-1:0] ma [3];
    logic [POS_W-1:0] mb [3];
    logic [2:0]       na, nb;

    always_comb begin
        ma[0] = i_side.mag[0]; na[0] = i_side.neg[0];
        mb[0] = i_side.mag[1]; nb[0] = !i_side.neg[1];
        ma[1] = i_side.mag[1]; na[1] = i_side.neg[1];
        mb[1] = i_side.mag[0]; nb[1] = i_side.neg[0];
        ma[2] = i_side.mag[2]; na[2] = i_side.neg[2];
        mb[2] = '0;            nb[2] = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: first products
            r1_rr_lo <= {32'b0, i_side.rsq[31:0]} * {32'b0, i_rad};
            r1_rr_hi <= {32'b0, i_side.rsq[63:32]} * {32'b0, i_rad};
            for (int c = 0; c < 3; c++) begin
                r1_mspd[c] <= {12'b0, ma[c]} * {32'b0, i_side.spd};
                r1_km[c]   <= {25'b0, mb[c]} * {32'b0, SPIRAL_K};
            end
            r1_na   <= na;
            r1_nb   <= nb;
            r1_rad  <= i_rad;
            r1_spd  <= i_side.spd;
            r1_zero <= i_side.zero;

            // stage 2: rsq*rad, K*|b|*rad partials
            r2_rr <= {r1_rr_hi, 32'b0} + {32'b0, r1_rr_lo};
            for (int c = 0; c < 3; c++) begin
                r2_t1[c]  <= {r1_mspd[c], 40'b0};
                r2_krl[c] <= {32'b0, r1_km[c][31:0]} * {32'b0, r1_rad};
                r2_krh[c] <= {32'b0, r1_km[c][KM_W-1:32]} * {25'b0, r1_rad};
            end
            r2_na   <= r1_na;
            r2_nb   <= r1_nb;
            r2_spd  <= r1_spd;
            r2_zero <= r1_zero;

            // stage 3: denominator partials
            r3_dp0 <= {12'b0, r2_rr[31:0]}  * {32'b0, r2_spd};
            r3_dp1 <= {12'b0, r2_rr[63:32]} * {32'b0, r2_spd};
            r3_dp2 <= {12'b0, r2_rr[95:64]} * {32'b0, r2_spd};
            for (int c = 0; c < 3; c++) begin
                r3_t1[c] <= r2_t1[c];
                r3_t2[c] <= {r2_krh[c], 32'b0} + {25'b0, r2_krl[c]};
            end
            r3_na   <= r2_na;
            r3_nb   <= r2_nb;
            r3_zero <= r2_zero;

            // stage 4: denominator, signed sum of the two terms
            r4_den <= {64'b0, r3_dp0} + {32'b0, r3_dp1, 32'b0} + {r3_dp2, 64'b0};
            for (int c = 0; c < 3; c++) begin
                if (r3_na[c] == r3_nb[c]) begin
                    r4_mag[c] <= {6'b0, r3_t1[c]} + {1'b0, r3_t2[c]};
                    r4_neg[c] <= r3_na[c];
                end else if ({5'b0, r3_t1[c]} >= r3_t2[c]) begin
                    r4_mag[c] <= {6'b0, r3_t1[c]} - {1'b0, r3_t2[c]};
                    r4_neg[c] <= r3_na[c];
                end else begin
                    r4_mag[c] <= {1'b0, r3_t2[c]} - {6'b0, r3_t1[c]};
                    r4_neg[c] <= r3_nb[c];
                end
            end
            r4_zero <= r3_zero;

            // stage 5: 2*5*2^16*mag + den over 2*den gives the rounded quotient
            for (int c = 0; c < 3; c++) begin
                r5_n2[c] <= {1'b0, r4_mag[c], 19'b0} + {3'b0, r4_mag[c], 17'b0}
                          + {2'b0, r4_den};
            end
            r5_d2   <= {r4_den, 1'b0};
            r5_neg  <= r4_neg;
            r5_zero <= r4_zero;
        end
    end

    assign o_vld       = r_vld[4];
    assign o_n2        = r5_n2;
    assign o_d2        = r5_d2;
    assign o_side.neg  = r5_neg;
    assign o_side.zero = r5_zero;

endmodule

FILE: rtl/psf_div.sv
// ----------------------------------------------------------------------------
// psf_div
// Three-lane pipelined restoring divider sharing one divisor, 32 quotient
// bits, with an overflow flag for quotients of 2^32 and up.
// ----------------------------------------------------------------------------
module psf_div
    import psf_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [N2_W-1:0] i_n2 [3],
    input  logic [D2_W-1:0] i_d2,
    input  t_div_side       i_side,
    output logic            o_vld,
    output logic [Q_W-1:0]  o_q [3],
    output logic [2:0]      o_ovf,
    output t_div_side       o_side
);

    localparam int TOP_W = N2_W - Q_W;

    // prep stage
    logic            r_p_vld;
    logic [D2_W-1:0] r_p_rem [3];
    logic [Q_W-1:0]  r_p_l   [3];
    logic [2:0]      r_p_ovf;
    logic [D2_W-1:0] r_p_d2;
    t_div_side       r_p_side;

    // step stages
    logic [DIV_STEPS-1:0] r_vld;
    logic [DIV_STEPS-1:0] n_vld;
    logic [D2_W-1:0]      r_rem  [DIV_STEPS][3];
    logic [D2_W-1:0]      n_rem  [DIV_STEPS][3];
    logic [Q_W-1:0]       r_l    [DIV_STEPS][3];
    logic [Q_W-1:0]       n_l    [DIV_STEPS][3];
    logic [2:0]           r_ovf  [DIV_STEPS];
    logic [2:0]           n_ovf  [DIV_STEPS];
    logic [D2_W-1:0]      r_d2   [DIV_STEPS];
    logic [D2_W-1:0]      n_d2   [DIV_STEPS];
    t_div_side            r_side [DIV_STEPS];
    t_div_side            n_side [DIV_STEPS];

    always_comb begin
        logic [D2_W-1:0] p_rem;
        logic [Q_W-1:0]  p_l;
        logic [D2_W:0]   sh;
        logic            ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (k == 0) begin
                n_vld[k]  = r_p_vld;
                n_ovf[k]  = r_p_ovf;
                n_d2[k]   = r_p_d2;
                n_side[k] = r_p_side;
            end else begin
                n_vld[k]  = r_vld[k-1];
                n_ovf[k]  = r_ovf[k-1];
                n_d2[k]   = r_d2[k-1];
                n_side[k] = r_side[k-1];
            end
            for (int c = 0; c < 3; c++) begin
                if (k == 0) begin
                    p_rem = r_p_rem[c];
                    p_l   = r_p_l[c];
                end else begin
                    p_rem = r_rem[k-1][c];
                    p_l   = r_l[k-1][c];
                end
                sh          = {p_rem, p_l[Q_W-1]};
                ge          = (sh >= {1'b0, n_d2[k]});
                n_rem[k][c] = ge ? D2_W'(sh - {1'b0, n_d2[k]}) : sh[D2_W-1:0];
                n_l[k][c]   = {p_l[Q_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_vld   <= '0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
            r_vld   <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // the upper numerator bits must stay below the divisor
            for (int c = 0; c < 3; c++) begin
                r_p_ovf[c] <= ({(D2_W-TOP_W)'(0), i_n2[c][N2_W-1:Q_W]} >= i_d2);
                r_p_rem[c] <= {(D2_W-TOP_W)'(0), i_n2[c][N2_W-1:Q_W]};
                r_p_l[c]   <= i_n2[c][Q_W-1:0];
            end
            r_p_d2   <= i_d2;
            r_p_side <= i_side;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_l[k]    <= n_l[k];
                r_ovf[k]  <= n_ovf[k];
                r_d2[k]   <= n_d2[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_q    = r_l[DIV_STEPS-1];
    assign o_ovf  = r_ovf[DIV_STEPS-1];
    assign o_side = r_side[DIV_STEPS-1];

endmodule

FILE: rtl/parker_spiral_field_unit.sv
// ----------------------------------------------------------------------------
// parker_spiral_field_unit
// Parker spiral magnetic field at a heliocentric position, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one position item per cycle unless stalled and returns one field
// item per item, in order, through 3 stages for magnitudes and r^2, 32 for
// the square root (one root bit per stage), 5 for the products, 33 for the
// three-lane divider (one quotient bit per stage) and the output register.
// The whole pipeline holds while the output item is stalled, so o_in_stall
// follows i_out_stall whenever an output item is waiting. The wind speed
// register is written through the cfg channel (always ready); a value of 0
// acts as 1 km/s. Write it only while no item is in flight.
module parker_spiral_field_unit
    import psf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_pos_item        i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_field_item      o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [SPD_W-1:0] i_cfg_data
);

    logic             en;
    logic [SPD_W-1:0] r_wind;

    logic                  r_a_vld;
    logic [2:0][POS_W-1:0] r_a_mag;
    logic [2:0]            r_a_neg;
    logic [SPD_W-1:0]      r_a_spd;
    logic                  r_b_vld;
    logic [2:0][63:0]      r_b_sq;
    logic [2:0][POS_W-1:0] r_b_mag;
    logic [2:0]            r_b_neg;
    logic [SPD_W-1:0]      r_b_spd;
    logic                  r_c_vld;
    t_sq_side              r_c_side;
    logic [RSQ_W-1:0]      n_rsq;

    logic             sq_vld;
    logic [RAD_W-1:0] sq_rad;
    t_sq_side         sq_side;
    logic             pr_vld;
    logic [N2_W-1:0]  pr_n2 [3];
    logic [D2_W-1:0]  pr_d2;
    t_div_side        pr_side;
    logic             dv_vld;
    logic [Q_W-1:0]   dv_q [3];
    logic [2:0]       dv_ovf;
    t_div_side        dv_side;

    logic             r_out_vld;
    t_field_item      r_out;
    t_field_item      n_out;

    assign en          = !(r_out_vld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wind <= WIND_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wind <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_a_vld   <= i_in_valid;
            r_b_vld   <= r_a_vld;
            r_c_vld   <= r_b_vld;
            r_out_vld <= dv_vld;
        end
    end

    assign n_rsq = r_b_sq[0] + r_b_sq[1] + r_b_sq[2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg <= {i_in_item.pos_z[31], i_in_item.pos_y[31], i_in_item.pos_x[31]};
            r_a_mag[0] <= i_in_item.pos_x[31] ? 32'(-i_in_item.pos_x) : i_in_item.pos_x;
            r_a_mag[1] <= i_in_item.pos_y[31] ? 32'(-i_in_item.pos_y) : i_in_item.pos_y;
            r_a_mag[2] <= i_in_item.pos_z[31] ? 32'(-i_in_item.pos_z) : i_in_item.pos_z;
            r_a_spd <= (r_wind == '0) ? SPD_W'(1) : r_wind;

            for (int c = 0; c < 3; c++) begin
                r_b_sq[c] <= {32'b0, r_a_mag[c]} * {32'b0, r_a_mag[c]};
            end
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            r_b_spd <= r_a_spd;

            r_c_side.rsq  <= n_rsq;
            r_c_side.zero <= (n_rsq == '0);
            r_c_side.mag  <= r_b_mag;
            r_c_side.neg  <= r_b_neg;
            r_c_side.spd  <= r_b_spd;

            r_out <= n_out;
        end
    end

    psf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_c_vld),
        .i_side  (r_c_side),
        .o_vld   (sq_vld),
        .o_rad   (sq_rad),
        .o_side  (sq_side)
    );

    psf_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_rad   (sq_rad),
        .i_side  (sq_side),
        .o_vld   (pr_vld),
        .o_n2    (pr_n2),
        .o_d2    (pr_d2),
        .o_side  (pr_side)
    );

    psf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (pr_vld),
        .i_n2    (pr_n2),
        .i_d2    (pr_d2),
        .i_side  (pr_side),
        .o_vld   (dv_vld),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_side  (dv_side)
    );

    // sign, saturation and the zero-radius override
    always_comb begin
        logic [31:0] val [3];
        logic        sat;
        sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (dv_side.neg[c]) begin
                if (dv_ovf[c] || dv_q[c] > 32'h8000_0000) begin
                    val[c] = 32'h8000_0000;
                    sat    = 1'b1;
                end else begin
                    val[c] = 32'(-dv_q[c]);
                end
            end else begin
                if (dv_ovf[c] || dv_q[c] > 32'h7FFF_FFFF) begin
                    val[c] = 32'h7FFF_FFFF;
                    sat    = 1'b1;
                end else begin
                    val[c] = dv_q[c];
                end
            end
        end
        if (dv_side.zero) begin
            n_out.field_x = '0;
            n_out.field_y = '0;
            n_out.field_z = '0;
            n_out.status  = ST_ZERO;
        end else begin
            n_out.field_x = val[0];
            n_out.field_y = val[1];
            n_out.field_z = val[2];
            n_out.status  = sat ? ST_SAT : ST_OK;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_ZERO) |->
        (o_out_item.field_x == 0 && o_out_item.field_y == 0 && o_out_item.field_z == 0))
        else $error("zero radius item with nonzero field");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_SAT) |->
        (o_out_item.field_x == 32'sh7FFF_FFFF || o_out_item.field_x == 32'sh8000_0000 ||
         o_out_item.field_y == 32'sh7FFF_FFFF || o_out_item.field_y == 32'sh8000_0000 ||
         o_out_item.field_z == 32'sh7FFF_FFFF || o_out_item.field_z == 32'sh8000_0000))
        else $error("saturated status without a clipped component");

    a_hold_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(dv_q[0]) && $stable(dv_vld)))
        else $error("pipeline moved while output item stalled");

endmodule
